>>> sv/ctra_pkg.sv
// shared types and codes of the contiguous transmit ring allocator
package ctra_pkg;

  localparam logic [2:0] ACT_QUERY  = 3'd0;
  localparam logic [2:0] ACT_ALLOC  = 3'd1;
  localparam logic [2:0] ACT_WRITE  = 3'd2;
  localparam logic [2:0] ACT_COMMIT = 3'd3;
  localparam logic [2:0] ACT_FREE   = 3'd4;
  localparam logic [2:0] ACT_DRAIN  = 3'd5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_QUERY,
    OP_ALLOC,
    OP_WRITE,
    OP_COMMIT,
    OP_FREE,
    OP_DRAIN,
    OP_BAD
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] req_size;
    logic [7:0] byte_offset;
    logic [7:0] data_byte;
    logic [7:0] free_address;
  } op_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] granted_size;
    logic [7:0] seg_start;
    logic [7:0] tx_byte;
  } res_t;

endpackage

>>> sv/ctra_ram.sv
// generic simple dual-port ram with registered read
module ctra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/ctra_front.sv
// front end: accepts input beats, classifies the action and queues up to two entries
module ctra_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,
  input  logic [2:0]    in_tuser,
  output logic          op_valid,
  output ctra_pkg::op_t op,
  input  logic          op_pop
);
  import ctra_pkg::*;

  op_t        q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  op_t        dec;
  logic       push;

  always_comb begin
    dec.req_size     = in_tdata[7:0];
    dec.byte_offset  = in_tdata[15:8];
    dec.data_byte    = in_tdata[23:16];
    dec.free_address = in_tdata[31:24];
    unique case (in_tuser)
      ACT_QUERY:  dec.kind = OP_QUERY;
      ACT_ALLOC:  dec.kind = OP_ALLOC;
      ACT_WRITE:  dec.kind = OP_WRITE;
      ACT_COMMIT: dec.kind = OP_COMMIT;
      ACT_FREE:   dec.kind = OP_FREE;
      ACT_DRAIN:  dec.kind = OP_DRAIN;
      default:    dec.kind = OP_BAD;
    endcase
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign op_valid  = (count_r != 2'd0);
  assign op        = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = op_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(op_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

>>> sv/ctra_back.sv
// back end: ring indices, grant logic, ring store and result register
module ctra_back #(
  parameter int RING_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           op_valid,
  input  ctra_pkg::op_t  op,
  output logic           op_pop,
  output logic           res_valid,
  output ctra_pkg::res_t res,
  input  logic           res_ready
);
  import ctra_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int WW = (AW > 8) ? AW : 8;

  typedef logic [AW-1:0] idx_t;
  typedef logic [WW-1:0] wide_t;
  typedef enum logic {BK_EXEC, BK_READ} bk_state_t;

  bk_state_t  state_r, state_nxt;
  idx_t       read_index_r, read_index_nxt;
  idx_t       write_index_r, write_index_nxt;
  idx_t       wrap_point_r, wrap_point_nxt;
  idx_t       pending_wrap_r, pending_wrap_nxt;
  idx_t       pending_start_r, pending_start_nxt;
  logic [7:0] pending_size_r, pending_size_nxt;
  logic       locked_r, locked_nxt;
  logic       res_valid_r, res_valid_nxt;
  res_t       res_r, res_nxt;

  logic       out_free;
  logic       mem_we, mem_re;
  idx_t       mem_waddr, mem_raddr;
  logic [7:0] mem_rdata;

  wide_t      rd_w, wr_w, req_w, tail_w, room_w, size_w;
  idx_t       g_wrap, g_start, rd_eff;
  logic [7:0] g_size;

  ctra_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (op.data_byte),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // largest contiguous run, at the write index or restarted at zero
  always_comb begin
    rd_w    = wide_t'(read_index_r);
    wr_w    = wide_t'(write_index_r);
    req_w   = wide_t'(op.req_size);
    tail_w  = wide_t'(RING_DEPTH - 1) - wr_w;
    room_w  = rd_w - wr_w - wide_t'(1);
    g_wrap  = wrap_point_r;
    g_start = write_index_r;
    size_w  = '0;
    if (rd_w > wr_w) begin
      size_w = (req_w > room_w) ? room_w : req_w;
    end else if (req_w < tail_w || tail_w >= rd_w) begin
      size_w = (req_w > tail_w) ? tail_w : req_w;
      g_wrap = AW'(wr_w + size_w);
    end else if (rd_w != '0) begin
      size_w  = (req_w > rd_w - wide_t'(1)) ? rd_w - wide_t'(1) : req_w;
      g_wrap  = write_index_r;
      g_start = '0;
    end
    g_size = 8'(size_w);
  end

  assign out_free = !res_valid_r || res_ready;
  assign rd_eff   = (read_index_r == wrap_point_r) ? '0 : read_index_r;

  always_comb begin
    state_nxt         = state_r;
    read_index_nxt    = read_index_r;
    write_index_nxt   = write_index_r;
    wrap_point_nxt    = wrap_point_r;
    pending_wrap_nxt  = pending_wrap_r;
    pending_start_nxt = pending_start_r;
    pending_size_nxt  = pending_size_r;
    locked_nxt        = locked_r;
    res_valid_nxt     = res_valid_r && !res_ready;
    res_nxt           = res_r;
    op_pop            = 1'b0;
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    mem_waddr         = AW'(wide_t'(pending_start_r) + wide_t'(op.byte_offset));
    mem_raddr         = rd_eff;
    unique case (state_r)
      BK_EXEC: begin
        if (op_valid && out_free) begin
          op_pop        = 1'b1;
          res_valid_nxt = 1'b1;
          res_nxt       = '{status: ST_BAD, granted_size: 8'd0, seg_start: 8'd0,
                            tx_byte: 8'd0};
          case (op.kind)
            OP_QUERY, OP_ALLOC: begin
              res_nxt.status = ST_NOSPACE;
              if (!locked_r) begin
                pending_wrap_nxt  = g_wrap;
                pending_start_nxt = g_start;
                if (g_size != 8'd0) begin
                  pending_size_nxt     = g_size;
                  locked_nxt           = (op.kind == OP_ALLOC);
                  res_nxt.status       = ST_OK;
                  res_nxt.granted_size = g_size;
                  res_nxt.seg_start    = 8'(g_start);
                end
              end
            end
            OP_WRITE: begin
              if (locked_r && op.byte_offset < pending_size_r) begin
                mem_we         = 1'b1;
                res_nxt.status = ST_OK;
              end
            end
            OP_COMMIT: begin
              if (op.req_size == 8'd0) begin
                res_nxt.status = ST_OK;
              end else if (locked_r && op.req_size <= pending_size_r) begin
                wrap_point_nxt  = pending_wrap_r;
                write_index_nxt = AW'(wide_t'(pending_start_r) + wide_t'(op.req_size));
                locked_nxt      = 1'b0;
                res_nxt.status  = ST_OK;
              end
            end
            OP_FREE: begin
              if (wide_t'(op.free_address) == wide_t'(pending_start_r)) begin
                locked_nxt     = 1'b0;
                res_nxt.status = ST_OK;
              end
            end
            OP_DRAIN: begin
              if (read_index_r != write_index_r) begin
                mem_re         = 1'b1;
                read_index_nxt = rd_eff + idx_t'(1);
                res_valid_nxt  = 1'b0;
                state_nxt      = BK_READ;
              end else begin
                res_nxt.status = ST_EMPTY;
              end
            end
            default: begin
              res_nxt.status = ST_BAD;
            end
          endcase
        end
      end
      BK_READ: begin
        if (out_free) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '{status: ST_OK, granted_size: 8'd0, seg_start: 8'd0,
                            tx_byte: mem_rdata};
          state_nxt     = BK_EXEC;
        end
      end
      default: begin
        state_nxt = BK_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= BK_EXEC;
      read_index_r    <= '0;
      write_index_r   <= '0;
      wrap_point_r    <= idx_t'(RING_DEPTH - 1);
      pending_wrap_r  <= idx_t'(RING_DEPTH - 1);
      pending_start_r <= idx_t'(RING_DEPTH - 1);
      pending_size_r  <= 8'd0;
      locked_r        <= 1'b0;
      res_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      read_index_r    <= read_index_nxt;
      write_index_r   <= write_index_nxt;
      wrap_point_r    <= wrap_point_nxt;
      pending_wrap_r  <= pending_wrap_nxt;
      pending_start_r <= pending_start_nxt;
      pending_size_r  <= pending_size_nxt;
      locked_r        <= locked_nxt;
      res_valid_r     <= res_valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

>>> sv/contiguous_tx_ring_allocator_core.sv
// top level of the contiguous transmit ring allocator
//
//   channel | direction | tdata (low bit up)                        | tuser
//   in_     | slave     | req_size, byte_offset, data_byte, free_addr | action
//   out_    | master    | granted_size, seg_start, tx_byte            | status
//
// with the queue empty a result is registered in the back end after its input beat is written into the front queue;
// a drain also waits on the registered ring store read
// sustained rate: one beat a cycle while out_tready keeps up; a drain holds the back end until its byte is out
// synchronous reset clears indices, lock and queue; the ring store is not cleared
// while the result register waits on out_tready the front queue takes up to two
// more beats, then in_tready drops
module contiguous_tx_ring_allocator_core #(
  parameter int RING_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // req_size, byte_offset, data_byte, free_address
  input  logic [2:0]  in_tuser,  // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // granted_size, seg_start, tx_byte
  output logic [1:0]  out_tuser  // status
);
  import ctra_pkg::*;

  logic op_valid;
  op_t  op;
  logic op_pop;
  res_t res;

  ctra_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .op_valid  (op_valid),
    .op        (op),
    .op_pop    (op_pop)
  );

  ctra_back #(.RING_DEPTH(RING_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op        (op),
    .op_pop    (op_pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  assign out_tdata = {res.tx_byte, res.seg_start, res.granted_size};
  assign out_tuser = res.status;

endmodule

>>> sv/ctra_checker.sv
// port-level checks of the ring allocator and their binding
module ctra_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import ctra_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == 24'd0)
    else $error("failed result carries payload");

  a_grant_or_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:0] != 8'd0 |-> out_tdata[23:16] == 8'd0)
    else $error("grant and drained byte in one beat");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

endmodule

bind contiguous_tx_ring_allocator_core ctra_checker u_checker (.*);

>>> bench/tb_contiguous_tx_ring_allocator_core.sv
// self-checking testbench for the contiguous transmit ring allocator core
import ctra_pkg::*;

typedef struct packed {
  logic [2:0] action;
  logic [7:0] req_size;
  logic [7:0] byte_offset;
  logic [7:0] data_byte;
  logic [7:0] free_address;
} ring_cmd_t;

class alloc_scoreboard;
  localparam int unsigned RING_SLOTS = 256;

  int unsigned rd_idx;
  int unsigned wr_idx;
  int unsigned wrap_pt;
  int unsigned pend_wrap;
  int unsigned pend_start;
  int unsigned pend_size;
  bit          locked;
  logic [7:0]  ring [RING_SLOTS];
  bit          filled [RING_SLOTS];
  res_t        replies_due[$];
  int          errors;
  int          taken;
  int          grants;
  int          drained;
  int          rejects;

  function new();
    rd_idx     = 0;
    wr_idx     = 0;
    wrap_pt    = RING_SLOTS - 1;
    pend_wrap  = RING_SLOTS - 1;
    pend_start = RING_SLOTS - 1;
    pend_size  = 0;
    locked     = 1'b0;
    foreach (ring[i]) begin
      ring[i]   = 8'h00;
      filled[i] = 1'b0;
    end
    errors  = 0;
    taken   = 0;
    grants  = 0;
    drained = 0;
    rejects = 0;
  endfunction

  // largest contiguous run up to req, at the write index or restarted at 0
  function int unsigned contiguous_grant(int unsigned req);
    int unsigned sz;
    int unsigned head;
    int unsigned tail;
    sz = req;
    pend_wrap  = wrap_pt;
    pend_start = wr_idx;
    if (rd_idx > wr_idx) begin
      if (sz > rd_idx - wr_idx - 1) sz = rd_idx - wr_idx - 1;
    end else begin
      head = rd_idx;
      tail = RING_SLOTS - 1 - wr_idx;
      if (sz < tail || tail >= head) begin
        if (sz > tail) sz = tail;
        pend_wrap = wr_idx + sz;
      end else if (head > 0) begin
        head = head - 1;
        if (sz > head) sz = head;
        pend_wrap  = wr_idx;
        pend_start = 0;
      end else begin
        sz = 0;
      end
    end
    return sz;
  endfunction

  // true when the next drain would read an entry never written
  function bit drain_hits_blank();
    int unsigned addr;
    if (rd_idx == wr_idx) return 1'b0;
    addr = (rd_idx == wrap_pt) ? 0 : rd_idx;
    return !filled[addr];
  endfunction

  function void note_action(ring_cmd_t c);
    res_t        r;
    int unsigned sz;
    int unsigned addr;
    r = '0;
    r.status = ST_BAD;
    case (c.action)
      ACT_QUERY, ACT_ALLOC: begin
        r.status = ST_NOSPACE;
        if (!locked) begin
          sz = contiguous_grant(c.req_size);
          if (sz > 0) begin
            pend_size = sz;
            if (c.action == ACT_ALLOC) locked = 1'b1;
            r.status       = ST_OK;
            r.granted_size = sz[7:0];
            r.seg_start    = pend_start[7:0];
            grants++;
          end
        end
      end
      ACT_WRITE: begin
        if (locked && c.byte_offset < pend_size) begin
          addr = (pend_start + c.byte_offset) % RING_SLOTS;
          ring[addr]   = c.data_byte;
          filled[addr] = 1'b1;
          r.status = ST_OK;
        end
      end
      ACT_COMMIT: begin
        if (c.req_size == 0) begin
          r.status = ST_OK;
        end else if (locked && c.req_size <= pend_size) begin
          wrap_pt = pend_wrap % RING_SLOTS;
          wr_idx  = (pend_start + c.req_size) % RING_SLOTS;
          locked  = 1'b0;
          r.status = ST_OK;
        end
      end
      ACT_FREE: begin
        if (c.free_address == pend_start) begin
          locked   = 1'b0;
          r.status = ST_OK;
        end
      end
      ACT_DRAIN: begin
        if (rd_idx != wr_idx) begin
          if (rd_idx == wrap_pt) rd_idx = 0;
          r.tx_byte = ring[rd_idx];
          rd_idx    = (rd_idx + 1) % RING_SLOTS;
          r.status  = ST_OK;
          drained++;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      default: ;
    endcase
    if (r.status != ST_OK) rejects++;
    taken++;
    replies_due.push_back(r);
  endfunction

  function void check_reply(res_t got);
    res_t want;
    if (replies_due.size() == 0) begin
      $error("result beat with nothing expected, status %0d", got.status);
      errors++;
      return;
    end
    want = replies_due.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.granted_size !== want.granted_size) begin
      $error("granted_size: expected %0d, got %0d", want.granted_size, got.granted_size);
      errors++;
    end
    if (got.seg_start !== want.seg_start) begin
      $error("seg_start: expected %0d, got %0d", want.seg_start, got.seg_start);
      errors++;
    end
    if (got.tx_byte !== want.tx_byte) begin
      $error("tx_byte: expected %0d, got %0d", want.tx_byte, got.tx_byte);
      errors++;
    end
  endfunction
endclass

module tb_contiguous_tx_ring_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int ITEM_TARGET   = 1550;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  alloc_scoreboard sb;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  int sent = 0;

  contiguous_tx_ring_allocator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned rand_byte();
    return $urandom_range(0, 255);
  endfunction

  task automatic send(input logic [2:0] act, input int unsigned req, input int unsigned off,
                      input int unsigned dat, input int unsigned fa);
    ring_cmd_t   c;
    int unsigned gap;
    c.action       = act;
    c.req_size     = req[7:0];
    c.byte_offset  = off[7:0];
    c.data_byte    = dat[7:0];
    c.free_address = fa[7:0];
    in_tvalid <= 1'b1;
    in_tuser  <= c.action;
    in_tdata  <= {c.free_address, c.data_byte, c.byte_offset, c.req_size};
    do @(posedge clk); while (!in_tready);
    sb.note_action(c);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
  endtask

  // fill every offset of the locked segment, in shuffled order half the time, with occasional out-of-range writes
  task automatic write_segment(input int unsigned size);
    int unsigned offs[$];
    int unsigned tmp;
    int unsigned j;
    int          i;
    for (i = 0; i < int'(size); i++) offs.push_back(i);
    if ($urandom_range(0, 1)) begin
      for (i = int'(size) - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = offs[i];
        offs[i] = offs[j];
        offs[j] = tmp;
      end
    end
    foreach (offs[k]) begin
      if ($urandom_range(0, 99) < 4)
        send(ACT_WRITE, rand_byte(), $urandom_range(size, 255), rand_byte(), rand_byte());
      send(ACT_WRITE, rand_byte(), offs[k], rand_byte(), rand_byte());
    end
  endtask

  task automatic run_frame();
    int unsigned r;
    int unsigned req;
    int unsigned size;
    if (sb.locked) send(ACT_FREE, rand_byte(), rand_byte(), rand_byte(), sb.pend_start);
    r = $urandom_range(0, 99);
    if (r < 60) req = $urandom_range(1, 24);
    else if (r < 85) req = $urandom_range(25, 100);
    else if (r < 97) req = $urandom_range(101, 255);
    else req = 0;
    send(ACT_ALLOC, req, rand_byte(), rand_byte(), rand_byte());
    if (!sb.locked) return;
    size = sb.pend_size;
    write_segment(size);
    r = $urandom_range(0, 99);
    if (r < 80) begin
      send(ACT_COMMIT, size, rand_byte(), rand_byte(), rand_byte());
    end else if (r < 90) begin
      send(ACT_COMMIT, $urandom_range(1, size), rand_byte(), rand_byte(), rand_byte());
    end else if (r < 95 && size < 255) begin
      send(ACT_COMMIT, $urandom_range(size + 1, 255), rand_byte(), rand_byte(), rand_byte());
      send(ACT_COMMIT, size, rand_byte(), rand_byte(), rand_byte());
    end else begin
      send(ACT_FREE, rand_byte(), rand_byte(), rand_byte(), sb.pend_start);
    end
  endtask

  task automatic drain_burst(input int unsigned n);
    repeat (n) begin
      if (sb.drain_hits_blank()) break;
      send(ACT_DRAIN, rand_byte(), rand_byte(), rand_byte(), rand_byte());
    end
  endtask

  task automatic noise_item();
    logic [2:0]  act;
    int unsigned req;
    int unsigned off;
    int unsigned fa;
    act = 3'($urandom_range(0, 7));
    req = $urandom_range(0, 1) ? $urandom_range(0, 16) : rand_byte();
    off = $urandom_range(0, 1) ? $urandom_range(0, 16) : rand_byte();
    fa  = ($urandom_range(0, 99) < 30) ? sb.pend_start : rand_byte();
    if (act == ACT_DRAIN && sb.drain_hits_blank()) act = ACT_QUERY;
    send(act, req, off, rand_byte(), fa);
  endtask

  // receiver: ready runs, stalls of random length and one long hold-off
  initial begin
    int unsigned stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(1, 16)) @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status       = status_t'(out_tuser);
      got.granted_size = out_tdata[7:0];
      got.seg_start    = out_tdata[15:8];
      got.tx_byte      = out_tdata[23:16];
      sb.check_reply(got);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_contiguous_tx_ring_allocator_core NOT OK");
    $finish;
  end

  initial begin
    int unsigned r;
    bit          held;
    bit          paused;
    sb = new();
    held = 1'b0;
    paused = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner cases straight out of reset
    send(ACT_DRAIN, 0, 0, 0, 0);
    send(ACT_WRITE, 0, 0, 8'hA5, 0);
    send(ACT_COMMIT, 0, 0, 0, 0);
    send(ACT_COMMIT, 5, 0, 0, 0);
    send(ACT_FREE, 0, 0, 0, 0);
    send(ACT_FREE, 0, 0, 0, 255);
    send(ACT_SPARE_LO, 255, 255, 255, 255);
    send(ACT_SPARE_HI, 0, 0, 0, 0);
    send(ACT_QUERY, 0, 0, 0, 0);
    send(ACT_QUERY, 255, 0, 0, 0);
    send(ACT_QUERY, 1, 0, 0, 0);

    // whole ring in one segment, so every reachable entry holds data
    send(ACT_ALLOC, 255, 0, 0, 0);
    send(ACT_QUERY, 4, 0, 0, 0);
    send(ACT_ALLOC, 4, 0, 0, 0);
    send(ACT_WRITE, 0, 255, 8'h5A, 0);
    send(ACT_COMMIT, 0, 0, 0, 0);
    write_segment(sb.pend_size);
    send(ACT_COMMIT, 255, 0, 0, 0);
    while (!sb.drain_hits_blank() && sb.rd_idx != sb.wr_idx)
      send(ACT_DRAIN, rand_byte(), rand_byte(), rand_byte(), rand_byte());
    send(ACT_DRAIN, 255, 255, 255, 255);

    // restart at index 0 and the lock rules around it
    send(ACT_ALLOC, 10, 0, 0, 0);
    send(ACT_WRITE, 0, 0, 8'hFF, 0);
    send(ACT_WRITE, 0, 9, 8'h00, 0);
    send(ACT_WRITE, 0, 10, 8'h3C, 0);
    send(ACT_COMMIT, 11, 0, 0, 0);
    send(ACT_FREE, 0, 0, 0, 3);
    send(ACT_FREE, 0, 0, 0, 0);
    send(ACT_COMMIT, 3, 0, 0, 0);
    send(ACT_QUERY, 255, 0, 0, 0);

    while (sent < ITEM_TARGET) begin
      if (!held && sent >= 700) begin
        hold_off = 1'b1;
        held = 1'b1;
      end
      if (!paused && sent >= 1000) begin
        settle();
        paused = 1'b1;
      end
      calm = (sent >= 1150 && sent < 1300);
      r = $urandom_range(0, 99);
      if (r < 65) run_frame();
      else if (r < 80) repeat ($urandom_range(1, 5)) noise_item();
      else drain_burst($urandom_range(1, 40));
    end
    calm = 1'b0;

    settle();
    repeat (10) @(posedge clk);
    $display("covered %0d actions: %0d grants, %0d bytes drained, %0d refused or rejected",
             sb.taken, sb.grants, sb.drained, sb.rejects);
    $display("with a %0d-cycle receiver hold-off, a full sender pause and gap-free stretches",
             HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("tb_contiguous_tx_ring_allocator_core OK");
    end else begin
      $display("tb_contiguous_tx_ring_allocator_core NOT OK");
    end
    $finish;
  end
endmodule
